>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// An implication, checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// A condition that must be followed by another one at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/edv_pkg.sv
// ----------------------------------------------------------------------------
// edv_pkg
// Types, codes and helper functions of the EDID block validator.
// ----------------------------------------------------------------------------
package edv_pkg;

	localparam int BLOCK_BYTES = 128;
	localparam int BLK_LOG2    = 7;

	// Byte positions inside the base block.
	localparam int POS_MFG_HI = 8;
	localparam int POS_MFG_LO = 9;
	localparam int POS_PRD_HI = 10;
	localparam int POS_PRD_LO = 11;
	localparam int POS_WEEK   = 16;
	localparam int POS_YEAR   = 17;
	localparam int POS_EXT    = 126;

	localparam logic [4:0] LETTER_MAX = 5'd26;

	// Error codes, ordered by priority.
	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_LENGTH   = 3'd1;
	localparam logic [2:0] ERR_HEADER   = 3'd2;
	localparam logic [2:0] ERR_BLOCKS   = 3'd3;
	localparam logic [2:0] ERR_CHECKSUM = 3'd4;
	localparam logic [2:0] ERR_MFG      = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic        valid_res;
		logic [2:0]  error_code;
		logic [15:0] manufacturer_id;
		logic [15:0] product_code;
		logic [7:0]  manufacture_week;
		logic [7:0]  manufacture_year;
	} report_t;

	// Expected header byte: 00 FF FF FF FF FF FF 00.
	function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
		logic [7:0] v;
		v = 8'hff;
		if (pos == 3'd0 || pos == 3'd7) begin
			v = 8'h00;
		end
		return v;
	endfunction

	function automatic logic letter_bad(input logic [4:0] v);
		return (v == 5'd0) || (v > LETTER_MAX);
	endfunction

endpackage

>>> rtl/edid_block_validator.sv
// ----------------------------------------------------------------------------
// edid_block_validator
// Streaming EDID blob check with identity capture.
// ----------------------------------------------------------------------------
// Bytes of an EDID blob enter one per cycle on the byte channel while
// byte_stall is low, the final byte marked by last. A byte passes an input
// register and then a result register, so a report appears in the result
// register in the cycle after its last byte leaves the input register and can
// wait there while the next blob already streams in. Only a report that
// is held by report_stall while another last byte arrives stops the input.
// The report gives the first failing check (length, header, block count,
// checksum, manufacturer letters) and the identity bytes that were captured;
// positions never received read as zero. Bytes past MAX_BLOCKS blocks are
// dropped and turn the report into a length error. After each report the
// block starts a new blob.
module edid_block_validator #(
	parameter int MAX_BLOCKS = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  edv_pkg::byte_item_t  byte_item,
	output logic                 report_valid,
	input  logic                 report_stall,
	output edv_pkg::report_t     report
);

	localparam int MAX_LEN = MAX_BLOCKS * edv_pkg::BLOCK_BYTES;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int BL      = edv_pkg::BLK_LOG2;

	// Input register.
	edv_pkg::byte_item_t byte_s1;
	logic                valid_s1;

	// Blob state.
	logic [CNT_W-1:0] count_q;
	logic [7:0]       sum_q;
	logic             ck_fail_q;
	logic             hdr_fail_q;
	logic             too_long_q;
	logic [7:0]       ext_q;
	logic [15:0]      mfg_q;
	logic [15:0]      prd_q;
	logic [7:0]       week_q;
	logic [7:0]       year_q;

	logic [CNT_W-1:0] count_n;
	logic [7:0]       sum_n;
	logic             ck_fail_n;
	logic             hdr_fail_n;
	logic             too_long_n;
	logic [7:0]       ext_n;
	logic [15:0]      mfg_n;
	logic [15:0]      prd_n;
	logic [7:0]       week_n;
	logic [7:0]       year_n;
	logic [7:0]       sum_add;

	edv_pkg::report_t report_q;
	logic             report_valid_q;
	logic [2:0]       err;
	logic [8:0]       ext_blocks;
	logic             out_free;
	logic             consume;

	assign out_free   = !report_valid_q || !report_stall;
	assign consume    = valid_s1 && (!byte_s1.last || out_free);
	assign byte_stall = valid_s1 && !consume;

	// Next blob state for the byte in the input register.
	always_comb begin
		count_n    = count_q;
		sum_n      = sum_q;
		ck_fail_n  = ck_fail_q;
		hdr_fail_n = hdr_fail_q;
		too_long_n = too_long_q;
		ext_n      = ext_q;
		mfg_n      = mfg_q;
		prd_n      = prd_q;
		week_n     = week_q;
		year_n     = year_q;
		sum_add    = sum_q + byte_s1.data_byte;
		if (count_q == CNT_W'(MAX_LEN)) begin
			too_long_n = 1'b1;
		end else begin
			if (count_q[CNT_W-1:3] == '0 &&
			    byte_s1.data_byte != edv_pkg::hdr_byte(count_q[2:0])) begin
				hdr_fail_n = 1'b1;
			end
			if (count_q == CNT_W'(edv_pkg::POS_MFG_HI)) begin
				mfg_n[15:8] = byte_s1.data_byte;
			end else if (count_q == CNT_W'(edv_pkg::POS_MFG_LO)) begin
				mfg_n[7:0] = byte_s1.data_byte;
			end else if (count_q == CNT_W'(edv_pkg::POS_PRD_HI)) begin
				prd_n[15:8] = byte_s1.data_byte;
			end else if (count_q == CNT_W'(edv_pkg::POS_PRD_LO)) begin
				prd_n[7:0] = byte_s1.data_byte;
			end else if (count_q == CNT_W'(edv_pkg::POS_WEEK)) begin
				week_n = byte_s1.data_byte;
			end else if (count_q == CNT_W'(edv_pkg::POS_YEAR)) begin
				year_n = byte_s1.data_byte;
			end else if (count_q == CNT_W'(edv_pkg::POS_EXT)) begin
				ext_n = byte_s1.data_byte;
			end
			// The last byte of each block closes its checksum.
			if (count_q[BL-1:0] == {BL{1'b1}}) begin
				if (sum_add != 8'h00) begin
					ck_fail_n = 1'b1;
				end
				sum_n = 8'h00;
			end else begin
				sum_n = sum_add;
			end
			count_n = count_q + CNT_W'(1);
		end
	end

	// Report for a blob that ends with this byte.
	always_comb begin
		ext_blocks = {1'b0, ext_n} + 9'd1;
		if (too_long_n || count_n[CNT_W-1:BL] == '0 || count_n[BL-1:0] != '0) begin
			err = edv_pkg::ERR_LENGTH;
		end else if (hdr_fail_n) begin
			err = edv_pkg::ERR_HEADER;
		end else if (ext_blocks != 9'(count_n[CNT_W-1:BL])) begin
			err = edv_pkg::ERR_BLOCKS;
		end else if (ck_fail_n) begin
			err = edv_pkg::ERR_CHECKSUM;
		end else if (edv_pkg::letter_bad(mfg_n[14:10]) || edv_pkg::letter_bad(mfg_n[9:5]) ||
		             edv_pkg::letter_bad(mfg_n[4:0])) begin
			err = edv_pkg::ERR_MFG;
		end else begin
			err = edv_pkg::ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			ck_fail_q  <= 1'b0;
			hdr_fail_q <= 1'b0;
			too_long_q <= 1'b0;
			ext_q      <= '0;
			mfg_q      <= '0;
			prd_q      <= '0;
			week_q     <= '0;
			year_q     <= '0;
		end else if (consume) begin
			if (byte_s1.last) begin
				count_q    <= '0;
				sum_q      <= '0;
				ck_fail_q  <= 1'b0;
				hdr_fail_q <= 1'b0;
				too_long_q <= 1'b0;
				ext_q      <= '0;
				mfg_q      <= '0;
				prd_q      <= '0;
				week_q     <= '0;
				year_q     <= '0;
			end else begin
				count_q    <= count_n;
				sum_q      <= sum_n;
				ck_fail_q  <= ck_fail_n;
				hdr_fail_q <= hdr_fail_n;
				too_long_q <= too_long_n;
				ext_q      <= ext_n;
				mfg_q      <= mfg_n;
				prd_q      <= prd_n;
				week_q     <= week_n;
				year_q     <= year_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (consume && byte_s1.last) begin
			report_valid_q <= 1'b1;
		end else if (!report_stall) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && byte_s1.last) begin
			report_q.valid_res        <= (err == edv_pkg::ERR_OK);
			report_q.error_code       <= err;
			report_q.manufacturer_id  <= mfg_n;
			report_q.product_code     <= prd_n;
			report_q.manufacture_week <= week_n;
			report_q.manufacture_year <= year_n;
		end
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

endmodule

>>> rtl/edv_checker.sv
// ----------------------------------------------------------------------------
// edv_checker
// Port-level assertions for the EDID block validator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edv_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input edv_pkg::byte_item_t byte_item,
	input logic                report_valid,
	input logic                report_stall,
	input edv_pkg::report_t    report
);

	// A stalled byte stays offered and unchanged.
	`ASSERT_NEXT(a_byte_holds, clk, arst_n, byte_valid && byte_stall,
		byte_valid && $stable(byte_item),
		"stalled byte changed")

	`ASSERT_IMPLIES(a_valid_matches_code, clk, arst_n, report_valid,
		report.valid_res == (report.error_code == edv_pkg::ERR_OK),
		"valid_res disagrees with error_code")

	`ASSERT_IMPLIES(a_code_in_range, clk, arst_n, report_valid,
		report.error_code <= edv_pkg::ERR_MFG,
		"error_code outside the defined codes")

	// A passing blob must carry three legal manufacturer letters.
	`ASSERT_IMPLIES(a_pass_letters_ok, clk, arst_n, report_valid && report.valid_res,
		!edv_pkg::letter_bad(report.manufacturer_id[14:10]) &&
		!edv_pkg::letter_bad(report.manufacturer_id[9:5]) &&
		!edv_pkg::letter_bad(report.manufacturer_id[4:0]),
		"passing report with a bad manufacturer letter")

	`ASSERT_NEXT(a_report_holds, clk, arst_n, report_valid && report_stall,
		report_valid && $stable(report),
		"stalled report changed")

endmodule

bind edid_block_validator edv_checker u_edv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.byte_item    (byte_item),
	.report_valid (report_valid),
	.report_stall (report_stall),
	.report       (report)
);
